// File: design/dtc_pkg.sv
package dtc_pkg;

    // Time format
    localparam int TIME_W    = 48;
    localparam int FRAC_BITS = 16;
    localparam int BPM_W     = 25;
    localparam int DELAY_W   = 32;

    // Bars to seconds: seconds = bars * 240 / bpm
    localparam int BAR_BEATS = 240;
    localparam int MULT_W    = 8;
    localparam int PROD_W    = TIME_W + MULT_W;
    localparam int NUM_W     = PROD_W + FRAC_BITS;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Remaining time sum: ref - now + delay, two guard bits
    localparam int REM_W = TIME_W + 2;

    localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_KIND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SELECT = 2'd2;

    // Delay kinds
    localparam logic [1:0] KIND_TRUE  = 2'd0;
    localparam logic [1:0] KIND_FALSE = 2'd1;
    localparam logic [1:0] KIND_BOTH  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Clock selection
    localparam logic [2:0] CS_FX_BARS    = 3'd0;
    localparam logic [2:0] CS_FX_SECS    = 3'd1;
    localparam logic [2:0] CS_LOCAL_BARS = 3'd2;
    localparam logic [2:0] CS_LOCAL_SECS = 3'd3;
    localparam logic [2:0] CS_PLAY_BARS  = 3'd4;
    localparam logic [2:0] CS_PLAY_SECS  = 3'd5;
    localparam logic [2:0] CS_RUN_SECS   = 3'd6;
    localparam logic [2:0] CS_ZERO       = 3'd7;

    // Reset values of the configuration registers
    localparam logic signed [DELAY_W-1:0] DELAY_LENGTH_RST = DELAY_W'(65536);
    localparam logic [1:0] DELAY_KIND_RST   = KIND_TRUE;
    localparam logic [2:0] CLOCK_SELECT_RST = CS_RUN_SECS;

    typedef struct packed {
        logic                     trigger_level;
        logic signed [TIME_W-1:0] fx_bars;
        logic signed [TIME_W-1:0] local_bars;
        logic signed [TIME_W-1:0] play_bars;
        logic signed [TIME_W-1:0] run_seconds;
        logic        [BPM_W-1:0]  tempo_bpm;
    } in_req_t;

    typedef struct packed {
        logic                     delayed_level;
        logic signed [TIME_W-1:0] time_left;
    } out_res_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [TIME_W-1:0] mag;
        logic [BPM_W-1:0]  bpm;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [TIME_W-1:0] secs;
    } div_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EVAL
    } state_t;

endpackage

// File: design/dtc_if.sv
interface dtc_in_if;
    logic             valid;
    logic             ready;
    dtc_pkg::in_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtc_out_if;
    logic              valid;
    logic              ready;
    dtc_pkg::out_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/dtc_div.sv
module dtc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dtc_pkg::div_req_t req,
    output dtc_pkg::div_rsp_t rsp
);

    logic                             busy_reg, busy_next;
    logic [dtc_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    logic [dtc_pkg::NUM_W-1:0]        num_reg, num_next;
    logic [dtc_pkg::BPM_W-1:0]        rem_reg, rem_next;
    logic [dtc_pkg::BPM_W-1:0]        bpm_reg, bpm_next;
    logic [dtc_pkg::TIME_W:0]         quo_reg, quo_next;
    logic                             ovf_reg, ovf_next;
    logic                             neg_reg, neg_next;
    logic signed [dtc_pkg::TIME_W-1:0] secs_reg, secs_next;

    logic [dtc_pkg::PROD_W-1:0] prod;
    logic [dtc_pkg::BPM_W:0]    trial;
    logic [dtc_pkg::BPM_W:0]    diff;
    logic                       fits;
    logic                       big;
    logic                       sat;
    logic [dtc_pkg::TIME_W-1:0] quo_neg;

    // Dividend scale: bars * 240, a constant multiply
    assign prod = {{dtc_pkg::MULT_W{1'b0}}, req.mag}
                  * dtc_pkg::PROD_W'(dtc_pkg::BAR_BEATS);

    // Shared compare-subtract unit, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[dtc_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, bpm_reg};
    assign fits  = (trial >= {1'b0, bpm_reg});

    // Saturation test on the final quotient
    assign big     = quo_reg[dtc_pkg::TIME_W] | ovf_reg;
    assign quo_neg = ~quo_reg[dtc_pkg::TIME_W-1:0] + dtc_pkg::TIME_W'(1);
    assign sat     = neg_reg
                     ? (big | (quo_reg[dtc_pkg::TIME_W-1] & (|quo_reg[dtc_pkg::TIME_W-2:0])))
                     : (big | quo_reg[dtc_pkg::TIME_W-1]);

    // Sequencer
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        rem_next  = rem_reg;
        bpm_next  = bpm_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        secs_next = secs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            num_next  = {prod, {dtc_pkg::FRAC_BITS{1'b0}}};
            rem_next  = '0;
            bpm_next  = req.bpm;
            quo_next  = '0;
            neg_next  = req.neg;
            // zero bars gives zero; zero tempo saturates at once
            if (req.mag == '0)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else if (req.bpm == '0)
            begin
                cnt_next = '0;
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next = dtc_pkg::CNT_W'(dtc_pkg::DIV_STEPS);
                ovf_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - dtc_pkg::CNT_W'(1);
                num_next = {num_reg[dtc_pkg::NUM_W-2:0], 1'b0};
                rem_next = fits ? diff[dtc_pkg::BPM_W-1:0] : trial[dtc_pkg::BPM_W-1:0];
                quo_next = {quo_reg[dtc_pkg::TIME_W-1:0], fits};
                ovf_next = ovf_reg | quo_reg[dtc_pkg::TIME_W];
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (sat)
                    secs_next = neg_reg ? dtc_pkg::TIME_MIN : dtc_pkg::TIME_MAX;
                else if (neg_reg)
                    secs_next = quo_neg;
                else
                    secs_next = quo_reg[dtc_pkg::TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        bpm_reg  <= bpm_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        secs_reg <= secs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.secs = secs_reg;

endmodule

// File: design/delayed_trigger_change_unit.sv
// Delayed trigger change unit.
// in_ch carries one request per frame: the raw trigger level, three bar
// clocks, the run clock and the tempo. out_ch returns one result for each
// request: the delayed level and the remaining delay time (saturated Q31.16).
// cfg_we/cfg_index/cfg_data write delay_length (0), delay_kind (1) and
// clock_select (2); write only while no request is in flight.
// A raw clock (bars, run seconds or zero) is taken as the current time when
// the request is accepted; ST_EVAL then loads the result for out_ch. A clock
// in seconds runs bars * 240 / bpm through a restoring divider in ST_CONV,
// one quotient bit per cycle over 72 bits, before ST_EVAL.
// One request at a time; in_ch.ready is high only while idle (ST_IDLE),
// so a new request is accepted only once the last one has left ST_EVAL.
// The result sits in an output register; a stalled receiver does not block
// acceptance of the next request, which waits at its evaluation step
// until the register is free.
// Reset clears the configuration to delay 1.0, delay true, run seconds,
// clears the recorded times and levels, and empties the output register.
module delayed_trigger_change_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    dtc_in_if.sink                         in_ch,
    dtc_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtc_pkg::DELAY_W-1:0]    cfg_data
);

    // Configuration
    logic signed [dtc_pkg::DELAY_W-1:0] delay_length_reg;
    logic [1:0]                         delay_kind_reg;
    logic [2:0]                         clock_select_reg;

    // Control
    dtc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            in_acc;
    logic            slot_free;
    logic            eval_fire;
    logic            is_secs;

    // Item and history
    logic                              trig_reg, trig_next;
    logic signed [dtc_pkg::TIME_W-1:0] now_reg, now_next;
    logic signed [dtc_pkg::TIME_W-1:0] last_true_reg, last_true_next;
    logic signed [dtc_pkg::TIME_W-1:0] last_false_reg, last_false_next;
    logic signed [dtc_pkg::TIME_W-1:0] last_edge_reg, last_edge_next;
    logic                              seen_reg, seen_next;
    logic                              lbe_reg, lbe_next;
    logic                              prev_out_reg, prev_out_next;
    dtc_pkg::out_res_t                 out_data_reg, out_data_next;

    // Datapath
    logic signed [dtc_pkg::TIME_W-1:0] sel_bars;
    logic signed [dtc_pkg::TIME_W-1:0] raw_now;
    logic signed [dtc_pkg::TIME_W-1:0] ref_time;
    logic                              held;
    logic                              changed;
    logic signed [dtc_pkg::REM_W-1:0]  rem;
    logic                              positive;
    logic                              result;
    logic signed [dtc_pkg::TIME_W-1:0] left;
    dtc_pkg::div_req_t                 div_req;
    dtc_pkg::div_rsp_t                 div_rsp;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= dtc_pkg::DELAY_LENGTH_RST;
            delay_kind_reg   <= dtc_pkg::DELAY_KIND_RST;
            clock_select_reg <= dtc_pkg::CLOCK_SELECT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtc_pkg::CFG_DELAY_LENGTH: delay_length_reg <= cfg_data;
                dtc_pkg::CFG_DELAY_KIND:   delay_kind_reg   <= cfg_data[1:0];
                dtc_pkg::CFG_CLOCK_SELECT: clock_select_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Clock selection
    always_comb
    begin
        case (clock_select_reg)
            dtc_pkg::CS_FX_SECS,
            dtc_pkg::CS_LOCAL_SECS,
            dtc_pkg::CS_PLAY_SECS: is_secs = 1'b1;
            default:               is_secs = 1'b0;
        endcase
        case (clock_select_reg)
            dtc_pkg::CS_FX_SECS:    sel_bars = in_ch.data.fx_bars;
            dtc_pkg::CS_LOCAL_SECS: sel_bars = in_ch.data.local_bars;
            default:                sel_bars = in_ch.data.play_bars;
        endcase
        case (clock_select_reg)
            dtc_pkg::CS_FX_BARS:    raw_now = in_ch.data.fx_bars;
            dtc_pkg::CS_LOCAL_BARS: raw_now = in_ch.data.local_bars;
            dtc_pkg::CS_PLAY_BARS:  raw_now = in_ch.data.play_bars;
            dtc_pkg::CS_RUN_SECS:   raw_now = in_ch.data.run_seconds;
            default:                raw_now = '0;
        endcase
    end

    // Divider request: magnitude and sign of the selected bar clock
    assign div_req.start = in_acc && is_secs;
    assign div_req.neg   = sel_bars[dtc_pkg::TIME_W-1];
    assign div_req.mag   = sel_bars[dtc_pkg::TIME_W-1] ? (~sel_bars + dtc_pkg::TIME_W'(1))
                                                       : sel_bars;
    assign div_req.bpm   = in_ch.data.tempo_bpm;

    dtc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtc_pkg::ST_IDLE:
                if (in_acc)
                    state_next = is_secs ? dtc_pkg::ST_CONV : dtc_pkg::ST_EVAL;
            dtc_pkg::ST_CONV:
                if (div_rsp.done)
                    state_next = dtc_pkg::ST_EVAL;
            dtc_pkg::ST_EVAL:
                if (slot_free)
                    state_next = dtc_pkg::ST_IDLE;
            default:
                state_next = dtc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ch.ready = (state_reg == dtc_pkg::ST_IDLE);
        eval_fire   = (state_reg == dtc_pkg::ST_EVAL) && slot_free;
    end

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;

    // History update as seen by this item
    assign changed         = (trig_reg != seen_reg);
    assign last_true_next  = (eval_fire && trig_reg) ? now_reg : last_true_reg;
    assign last_false_next = (eval_fire && !trig_reg) ? now_reg : last_false_reg;
    assign last_edge_next  = (eval_fire && changed) ? now_reg : last_edge_reg;
    assign lbe_next        = (eval_fire && changed) ? prev_out_reg : lbe_reg;
    assign seen_next       = eval_fire ? trig_reg : seen_reg;

    // Reference time and held level of the delay kind
    always_comb
    begin
        case (delay_kind_reg)
            dtc_pkg::KIND_TRUE:
            begin
                ref_time = last_true_next;
                held     = 1'b1;
            end
            dtc_pkg::KIND_FALSE:
            begin
                ref_time = last_false_next;
                held     = 1'b0;
            end
            dtc_pkg::KIND_BOTH:
            begin
                ref_time = last_edge_next;
                held     = lbe_next;
            end
            default:
            begin
                ref_time = '0;
                held     = 1'b0;
            end
        endcase
    end

    // Remaining time and saturation to the output width
    assign rem = dtc_pkg::REM_W'(ref_time) - dtc_pkg::REM_W'(now_reg)
                 + dtc_pkg::REM_W'(delay_length_reg);
    assign positive = !rem[dtc_pkg::REM_W-1] && (rem != '0);
    assign result   = positive ? held : trig_reg;

    always_comb
    begin
        if (!rem[dtc_pkg::REM_W-1] && (rem[dtc_pkg::REM_W-2] || rem[dtc_pkg::REM_W-3]))
            left = dtc_pkg::TIME_MAX;
        else if (rem[dtc_pkg::REM_W-1] && !(rem[dtc_pkg::REM_W-2] && rem[dtc_pkg::REM_W-3]))
            left = dtc_pkg::TIME_MIN;
        else
            left = rem[dtc_pkg::TIME_W-1:0];
    end

    // Item capture, current time and output slot
    always_comb
    begin
        trig_next      = in_acc ? in_ch.data.trigger_level : trig_reg;
        now_next       = now_reg;
        if (in_acc && !is_secs)
            now_next = raw_now;
        else if ((state_reg == dtc_pkg::ST_CONV) && div_rsp.done)
            now_next = div_rsp.secs;
        prev_out_next  = eval_fire ? result : prev_out_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (eval_fire)
        begin
            out_data_next.delayed_level = result;
            out_data_next.time_left     = left;
            out_valid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtc_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_true_reg  <= '0;
            last_false_reg <= '0;
            last_edge_reg  <= '0;
            seen_reg       <= 1'b0;
            lbe_reg        <= 1'b0;
            prev_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            last_true_reg  <= last_true_next;
            last_false_reg <= last_false_next;
            last_edge_reg  <= last_edge_next;
            seen_reg       <= seen_next;
            lbe_reg        <= lbe_next;
            prev_out_reg   <= prev_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg     <= trig_next;
        now_reg      <= now_next;
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

// File: design/dtc_checker.sv
module dtc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input dtc_pkg::out_res_t out_data
);

    // One request in flight: acceptance closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after accepting a request");

    // An idle block with no request stays ready
    a_idle_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !in_valid) |=> in_ready)
        else $error("ready dropped without a request");

    // A new result is produced only while the input side is closed
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

endmodule

bind delayed_trigger_change_unit dtc_checker u_dtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_PHASES   = 15;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 200;

    localparam logic signed [dtc_pkg::TIME_W-1:0] ONE_SEC  = 48'sd65536;
    localparam logic signed [dtc_pkg::TIME_W-1:0] HALF_SEC = 48'sd32768;
    localparam logic [dtc_pkg::BPM_W-1:0] TEMPO_120 = 25'(120 << dtc_pkg::FRAC_BITS);
    localparam logic [dtc_pkg::BPM_W-1:0] TEMPO_TOP = {dtc_pkg::BPM_W{1'b1}};

    localparam logic [2:0] CLOCK_LIST [8] = '{dtc_pkg::CS_FX_BARS, dtc_pkg::CS_FX_SECS,
        dtc_pkg::CS_LOCAL_BARS, dtc_pkg::CS_LOCAL_SECS, dtc_pkg::CS_PLAY_BARS,
        dtc_pkg::CS_PLAY_SECS, dtc_pkg::CS_RUN_SECS, dtc_pkg::CS_ZERO};
    localparam logic [1:0] KIND_LIST [4] = '{dtc_pkg::KIND_TRUE, dtc_pkg::KIND_FALSE,
        dtc_pkg::KIND_BOTH, dtc_pkg::KIND_NONE};

    // Predicts the delayed level and the time left for each request
    class trigger_delay_scoreboard;
        logic signed [dtc_pkg::DELAY_W-1:0] delay_len;
        logic [1:0]                         kind;
        logic [2:0]                         clock_sel;
        logic signed [dtc_pkg::TIME_W-1:0]  true_at;
        logic signed [dtc_pkg::TIME_W-1:0]  false_at;
        logic signed [dtc_pkg::TIME_W-1:0]  edge_at;
        logic                               level_seen;
        logic                               level_held;
        logic                               output_seen;
        dtc_pkg::out_res_t                  expected_q[$];
        int                                 accepted;
        int                                 compared;
        int                                 errors;

        function new();
            delay_len   = dtc_pkg::DELAY_LENGTH_RST;
            kind        = dtc_pkg::DELAY_KIND_RST;
            clock_sel   = dtc_pkg::CLOCK_SELECT_RST;
            true_at     = '0;
            false_at    = '0;
            edge_at     = '0;
            level_seen  = 1'b0;
            level_held  = 1'b0;
            output_seen = 1'b0;
            accepted    = 0;
            compared    = 0;
            errors      = 0;
        endfunction

        function void set_register(logic [dtc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [dtc_pkg::DELAY_W-1:0] value);
            case (idx)
                dtc_pkg::CFG_DELAY_LENGTH: delay_len = value;
                dtc_pkg::CFG_DELAY_KIND:   kind = value[1:0];
                dtc_pkg::CFG_CLOCK_SELECT: clock_sel = value[2:0];
                default: ;
            endcase
        endfunction

        // bars * 240 / bpm, truncated toward zero, saturated to the time range
        function logic signed [dtc_pkg::TIME_W-1:0] bars_to_seconds(
                logic signed [dtc_pkg::TIME_W-1:0] bars,
                logic [dtc_pkg::BPM_W-1:0] bpm);
            logic signed [79:0] wide_bars;
            logic [79:0]        mag;
            logic [79:0]        quo;
            logic [79:0]        lim;
            logic               neg;
            neg       = bars[dtc_pkg::TIME_W-1];
            wide_bars = 80'(bars);
            mag       = neg ? -wide_bars : wide_bars;
            lim       = neg ? (80'd1 << (dtc_pkg::TIME_W-1))
                            : ((80'd1 << (dtc_pkg::TIME_W-1)) - 80'd1);
            if (mag == 0)
                return '0;
            // zero tempo pins the result to the extreme with the sign of bars
            if (bpm == 0)
                return neg ? dtc_pkg::TIME_MIN : dtc_pkg::TIME_MAX;
            quo = ((mag * dtc_pkg::BAR_BEATS) << dtc_pkg::FRAC_BITS) / bpm;
            if (quo > lim)
                return neg ? dtc_pkg::TIME_MIN : dtc_pkg::TIME_MAX;
            return neg ? -quo[dtc_pkg::TIME_W-1:0] : quo[dtc_pkg::TIME_W-1:0];
        endfunction

        function void note_request(dtc_pkg::in_req_t r);
            logic signed [dtc_pkg::TIME_W-1:0] now;
            logic signed [dtc_pkg::TIME_W-1:0] ref_time;
            logic signed [dtc_pkg::REM_W-1:0]  remaining;
            logic                              held;
            dtc_pkg::out_res_t                 e;
            case (clock_sel)
                dtc_pkg::CS_FX_BARS:    now = r.fx_bars;
                dtc_pkg::CS_FX_SECS:    now = bars_to_seconds(r.fx_bars, r.tempo_bpm);
                dtc_pkg::CS_LOCAL_BARS: now = r.local_bars;
                dtc_pkg::CS_LOCAL_SECS: now = bars_to_seconds(r.local_bars, r.tempo_bpm);
                dtc_pkg::CS_PLAY_BARS:  now = r.play_bars;
                dtc_pkg::CS_PLAY_SECS:  now = bars_to_seconds(r.play_bars, r.tempo_bpm);
                dtc_pkg::CS_RUN_SECS:   now = r.run_seconds;
                default:                now = '0;
            endcase

            // edge: remember when, and what the output was just before
            if (r.trigger_level != level_seen)
            begin
                edge_at    = now;
                level_held = output_seen;
            end
            level_seen = r.trigger_level;
            if (r.trigger_level)
                true_at = now;
            else
                false_at = now;

            case (kind)
                dtc_pkg::KIND_TRUE:  ref_time = true_at;
                dtc_pkg::KIND_FALSE: ref_time = false_at;
                dtc_pkg::KIND_BOTH:  ref_time = edge_at;
                default:             ref_time = '0;
            endcase
            held = (kind == dtc_pkg::KIND_TRUE) || (kind == dtc_pkg::KIND_BOTH && level_held);

            // exact sum with guard bits, then saturate
            remaining       = dtc_pkg::REM_W'(ref_time) - dtc_pkg::REM_W'(now)
                              + dtc_pkg::REM_W'(delay_len);
            e.delayed_level = (remaining > 0) ? held : r.trigger_level;
            output_seen     = e.delayed_level;
            if (remaining > dtc_pkg::REM_W'(dtc_pkg::TIME_MAX))
                e.time_left = dtc_pkg::TIME_MAX;
            else if (remaining < dtc_pkg::REM_W'(dtc_pkg::TIME_MIN))
                e.time_left = dtc_pkg::TIME_MIN;
            else
                e.time_left = remaining[dtc_pkg::TIME_W-1:0];
            expected_q.push_back(e);
            accepted++;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("ERROR at %0t: %s", $realtime, what);
        endfunction

        function void check_result(dtc_pkg::out_res_t got);
            dtc_pkg::out_res_t want;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("result with no request outstanding: level %0b left %0d",
                               got.delayed_level, got.time_left));
                return;
            end
            want = expected_q.pop_front();
            compared++;
            if (got.delayed_level !== want.delayed_level)
                flag($sformatf("result %0d delayed_level expected %0b actual %0b",
                               compared, want.delayed_level, got.delayed_level));
            if (got.time_left !== want.time_left)
                flag($sformatf("result %0d time_left expected %0d actual %0d",
                               compared, want.time_left, got.time_left));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag_leftovers();
            while (expected_q.size() != 0)
            begin
                void'(expected_q.pop_front());
                flag("expected result never arrived");
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [dtc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dtc_pkg::DELAY_W-1:0]   cfg_data;

    bit idle_on;
    bit stall_on;
    int hold_requests;
    int phases;
    int cycles;

    // transport clocks of the well-formed frame sequence
    logic signed [dtc_pkg::TIME_W-1:0] fx_pos;
    logic signed [dtc_pkg::TIME_W-1:0] loc_pos;
    logic signed [dtc_pkg::TIME_W-1:0] play_pos;
    logic signed [dtc_pkg::TIME_W-1:0] run_pos;
    logic                              trig_now;
    logic [dtc_pkg::BPM_W-1:0]         tempo_now;

    trigger_delay_scoreboard sb = new();

    dtc_in_if  in_ch ();
    dtc_out_if out_ch ();

    delayed_trigger_change_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sample both handshakes at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data);
        end
    end

    // Result side: random short stalls and one long hold-off on request
    initial
    begin
        int holds_served;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [dtc_pkg::TIME_W-1:0] any_time();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[dtc_pkg::TIME_W-1:0];
    endfunction

    function automatic dtc_pkg::in_req_t make_frame(logic trig,
                                                    logic signed [dtc_pkg::TIME_W-1:0] fx,
                                                    logic signed [dtc_pkg::TIME_W-1:0] loc,
                                                    logic signed [dtc_pkg::TIME_W-1:0] play,
                                                    logic signed [dtc_pkg::TIME_W-1:0] run,
                                                    logic [dtc_pkg::BPM_W-1:0] bpm);
        dtc_pkg::in_req_t r;
        r.trigger_level = trig;
        r.fx_bars       = fx;
        r.local_bars    = loc;
        r.play_bars     = play;
        r.run_seconds   = run;
        r.tempo_bpm     = bpm;
        return r;
    endfunction

    // Clocks move forward a little each frame; the trigger flips now and then
    function automatic dtc_pkg::in_req_t next_frame();
        fx_pos   += 48'($urandom_range(0, 16384));
        loc_pos  += 48'($urandom_range(0, 16384));
        play_pos += 48'($urandom_range(0, 16384));
        run_pos  += 48'($urandom_range(0, 32768));
        if ($urandom_range(0, 3) == 0)
            trig_now = ~trig_now;
        return make_frame(trig_now, fx_pos, loc_pos, play_pos, run_pos, tempo_now);
    endfunction

    function automatic dtc_pkg::in_req_t noise_frame();
        return make_frame(1'($urandom_range(0, 1)), any_time(), any_time(), any_time(),
                          any_time(),
                          dtc_pkg::BPM_W'($urandom_range(1, (1 << dtc_pkg::BPM_W) - 1)));
    endfunction

    function automatic logic [dtc_pkg::DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return $urandom();
            4:       return -dtc_pkg::DELAY_W'($urandom_range(0, 131072));
            default: return dtc_pkg::DELAY_W'($urandom_range(1, 262144));
        endcase
    endfunction

    // occasionally set bits above the register's width
    function automatic logic [dtc_pkg::DELAY_W-1:0] with_junk(
            logic [dtc_pkg::DELAY_W-1:0] code,
            logic [dtc_pkg::DELAY_W-1:0] keep);
        if ($urandom_range(0, 3) == 0)
            return ($urandom() & ~keep) | code;
        return code;
    endfunction

    task automatic write_reg(input logic [dtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtc_pkg::DELAY_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic send_request(input dtc_pkg::in_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Stop offering and wait until every expected result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        idle_on       = 1'b1;
        stall_on      = 1'b1;
        hold_requests = 0;
        phases        = 0;
        trig_now      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no time seeded, output held true until 1.0 after the last true level
        send_request(make_frame(1'b0, '0, '0, '0, '0, TEMPO_120));
        send_request(make_frame(1'b0, '0, '0, '0, HALF_SEC, TEMPO_120));
        send_request(make_frame(1'b1, '0, '0, '0, ONE_SEC, TEMPO_120));
        send_request(make_frame(1'b0, '0, '0, '0, ONE_SEC + HALF_SEC, TEMPO_120));
        send_request(make_frame(1'b0, '0, '0, '0, 3 * ONE_SEC, TEMPO_120));
        send_request(make_frame(1'b1, '0, '0, '0, dtc_pkg::TIME_MAX, TEMPO_120));
        send_request(make_frame(1'b0, '0, '0, '0, dtc_pkg::TIME_MIN, TEMPO_120));
        wait_drained();
        phases++;

        // Every clock select and delay kind against field extremes
        for (int s = 0; s < 8; s++)
        begin
            write_reg(dtc_pkg::CFG_DELAY_LENGTH, (s < 4) ? 32'h7FFF_FFFF : 32'h8000_0000);
            write_reg(dtc_pkg::CFG_DELAY_KIND, dtc_pkg::DELAY_W'(KIND_LIST[s % 4]));
            write_reg(dtc_pkg::CFG_CLOCK_SELECT, dtc_pkg::DELAY_W'(CLOCK_LIST[s]));
            if (s % 2 == 0)
                send_request(make_frame(1'b1, dtc_pkg::TIME_MAX, dtc_pkg::TIME_MAX,
                                        dtc_pkg::TIME_MAX, dtc_pkg::TIME_MAX, TEMPO_TOP));
            else
                send_request(make_frame(1'b0, dtc_pkg::TIME_MIN, dtc_pkg::TIME_MIN,
                                        dtc_pkg::TIME_MIN, dtc_pkg::TIME_MIN, 25'd1));
            wait_drained();
            phases++;
        end

        // Seconds conversion corners: zero tempo, saturation; high register bits ignored
        write_reg(dtc_pkg::CFG_DELAY_LENGTH, 32'h0000_8000);
        write_reg(dtc_pkg::CFG_DELAY_KIND,
                  32'hFFFF_FFFC | dtc_pkg::DELAY_W'(dtc_pkg::KIND_BOTH));
        write_reg(dtc_pkg::CFG_CLOCK_SELECT,
                  32'hFFFF_FFF8 | dtc_pkg::DELAY_W'(dtc_pkg::CS_PLAY_SECS));
        send_request(make_frame(1'b1, '0, '0, ONE_SEC, '0, '0));
        send_request(make_frame(1'b0, '0, '0, '0, '0, '0));
        send_request(make_frame(1'b1, '0, '0, -ONE_SEC, '0, '0));
        send_request(make_frame(1'b0, '0, '0, dtc_pkg::TIME_MIN, '0, 25'd1));
        send_request(make_frame(1'b1, '0, '0, dtc_pkg::TIME_MAX, '0, TEMPO_TOP));
        wait_drained();
        phases++;

        // Random settings, each with a run of advancing frames and some noise
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_on  = (p < RANDOM_PHASES - 2);
            stall_on = idle_on;
            write_reg(dtc_pkg::CFG_DELAY_LENGTH, pick_delay());
            write_reg(dtc_pkg::CFG_DELAY_KIND,
                      with_junk(dtc_pkg::DELAY_W'(KIND_LIST[$urandom_range(0, 3)]), 32'h3));
            write_reg(dtc_pkg::CFG_CLOCK_SELECT,
                      with_junk(dtc_pkg::DELAY_W'(CLOCK_LIST[$urandom_range(0, 7)]), 32'h7));
            fx_pos    = 48'($urandom_range(0, 2000000)) - 48'd1000000;
            loc_pos   = 48'($urandom_range(0, 2000000)) - 48'd1000000;
            play_pos  = 48'($urandom_range(0, 2000000)) - 48'd1000000;
            run_pos   = 48'($urandom_range(0, 2000000)) - 48'd1000000;
            tempo_now = dtc_pkg::BPM_W'($urandom_range(60, 200)) << dtc_pkg::FRAC_BITS;
            // fill the block while results are held back
            if (p == 2)
                hold_requests++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(noise_frame());
                else
                    send_request(next_frame());
            end
            wait_drained();
            phases++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flag_leftovers();
        $display("Covered %0d requests over %0d register settings, all clock selects and kinds",
                 sb.accepted, phases);
        $display("Compared %0d results, %0d failures", sb.compared, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
design/dtc_pkg.sv
design/dtc_if.sv
design/dtc_div.sv
design/delayed_trigger_change_unit.sv
design/dtc_checker.sv
tb/sv/testbench.sv
